// File: src/lkv_pkg.sv
// lkv_pkg: shared types and constants for the LRU key/value cache.
// Used by lkv_cell and lru_key_value_cache_unit; depends on nothing.
package lkv_pkg;

  localparam int KeyW   = 32;
  localparam int ValW   = 32;
  localparam int CapW   = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic KindGet = 1'b0;
  localparam logic KindPut = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lkv_state_t;

  // Entry handed from one cell to the next (toward least recent).
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } lkv_ent_t;

  // Scan results gathered along the row.
  typedef struct packed {
    logic            seen;   // a match lies at this cell or closer to the head
    logic [ValW-1:0] hv;     // value of the matching cell
    logic [KeyW-1:0] ek;     // key of the last valid cell so far
  } lkv_scan_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic            match_en;
    logic            commit;
    logic            hit;
    logic            evict;
    logic [KeyW-1:0] key;
  } lkv_ctl_t;

endpackage

// File: src/lkv_cell.sv
// lkv_cell: one recency slot of the LRU row, holding a key, a value and a
// valid bit. Uses lkv_pkg types; instantiated by lru_key_value_cache_unit.
module lkv_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lkv_pkg::lkv_ctl_t  ctl,
  input  lkv_pkg::lkv_ent_t  ent_in,
  output lkv_pkg::lkv_ent_t  ent_out,
  input  lkv_pkg::lkv_scan_t scan_in,
  output lkv_pkg::lkv_scan_t scan_out
);

  logic                      valid_r, valid_nxt;
  logic [lkv_pkg::KeyW-1:0]  key_r, key_nxt;
  logic [lkv_pkg::ValW-1:0]  value_r, value_nxt;
  logic                      match_r, match_nxt;
  logic                      move;

  // On a hit, cells up to the matching one step back; on an insert, every
  // held cell steps back (plus the first empty one when nothing is evicted).
  always_comb begin
    if (ctl.hit) begin
      move = ~scan_in.seen;
    end else if (ctl.evict) begin
      move = valid_r;
    end else begin
      move = ent_in.valid;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    match_nxt = match_r;
    if (ctl.commit && move) begin
      valid_nxt = ent_in.valid;
      key_nxt   = ent_in.key;
      value_nxt = ent_in.value;
    end
    if (ctl.match_en) begin
      match_nxt = valid_r && (key_r == ctl.key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    match_r <= match_nxt;
  end

  assign ent_out.valid = valid_r;
  assign ent_out.key   = key_r;
  assign ent_out.value = value_r;

  assign scan_out.seen = scan_in.seen | match_r;
  assign scan_out.hv   = match_r ? value_r : scan_in.hv;
  assign scan_out.ek   = valid_r ? key_r : scan_in.ek;

endmodule

// File: src/lru_key_value_cache_unit.sv
// lru_key_value_cache_unit: fully associative LRU key/value cache built as a
// row of lkv_cell slots kept in recency order. Depends on lkv_pkg, lkv_cell.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_stall  in_kind, in_key, in_write_value
//   out_*        out  out_valid / out_stall out_hit, out_read_value,
//                                          out_evicted, out_evicted_key
//   cfg_*        in   cfg_wr_en            cfg_wr_data (capacity_in_use)
//
// An item passes through ST_MATCH, where every cell compares its key, and then
// ST_UPDATE, where the row shifts toward the tail on a hit or a put and the
// result is registered. The next item can be taken in ST_UPDATE, while the
// last one completes. The update waits while the output register holds a
// beat that is stalled. Reset (rst_n low, synchronous) empties the cache and
// sets the capacity to 16; no clearing pass is needed.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [lkv_pkg::KeyW-1:0]        in_key,
  input  logic signed [lkv_pkg::ValW-1:0] in_write_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic signed [lkv_pkg::ValW-1:0] out_read_value,
  output logic                            out_evicted,
  output logic [lkv_pkg::KeyW-1:0]        out_evicted_key,
  input  logic                            cfg_wr_en,
  input  logic [lkv_pkg::CapW-1:0]        cfg_wr_data
);

  localparam int OccW = $clog2(ENTRIES + 1);
  localparam int CmpW = (OccW > lkv_pkg::CapW) ? OccW : lkv_pkg::CapW;

  lkv_pkg::lkv_state_t state_r, state_nxt;

  logic [lkv_pkg::CapW-1:0]  cap_r, cap_nxt;
  logic [OccW-1:0]           occ_r, occ_nxt;

  logic                      req_kind_r, req_kind_nxt;
  logic [lkv_pkg::KeyW-1:0]  req_key_r, req_key_nxt;
  logic [lkv_pkg::ValW-1:0]  req_val_r, req_val_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_hit_r, out_hit_nxt;
  logic [lkv_pkg::ValW-1:0]  out_rv_r, out_rv_nxt;
  logic                      out_ev_r, out_ev_nxt;
  logic [lkv_pkg::KeyW-1:0]  out_ek_r, out_ek_nxt;

  logic                      in_take;
  logic                      out_free;
  logic                      hit;
  logic                      evict;
  logic                      commit;
  logic [CmpW-1:0]           cap_ext;
  logic [CmpW-1:0]           eff_cap;

  lkv_pkg::lkv_ctl_t         ctl;
  lkv_pkg::lkv_ent_t         ent_link  [ENTRIES+1];
  lkv_pkg::lkv_scan_t        scan_link [ENTRIES+1];

  // Capacity of zero acts as one; above the row length it saturates.
  always_comb begin
    cap_ext = CmpW'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(ENTRIES)) begin
      eff_cap = CmpW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign out_free = ~out_valid_r | ~out_stall;
  assign hit      = scan_link[ENTRIES].seen;
  assign evict    = (req_kind_r == lkv_pkg::KindPut) && ~hit &&
                    (CmpW'(occ_r) >= eff_cap);
  assign commit   = (state_r == lkv_pkg::ST_UPDATE) && out_free &&
                    (hit || (req_kind_r == lkv_pkg::KindPut));

  always_comb begin
    in_stall = 1'b1;
    case (state_r)
      lkv_pkg::ST_IDLE:   in_stall = 1'b0;
      lkv_pkg::ST_MATCH:  in_stall = 1'b1;
      lkv_pkg::ST_UPDATE: in_stall = ~out_free;
      default:            in_stall = 1'b1;
    endcase
  end

  assign in_take = in_valid & ~in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkv_pkg::ST_IDLE: begin
        if (in_take) state_nxt = lkv_pkg::ST_MATCH;
      end
      lkv_pkg::ST_MATCH: begin
        state_nxt = lkv_pkg::ST_UPDATE;
      end
      lkv_pkg::ST_UPDATE: begin
        if (out_free) state_nxt = in_take ? lkv_pkg::ST_MATCH : lkv_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkv_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cap_nxt      = cfg_wr_en ? cfg_wr_data : cap_r;
    req_kind_nxt = in_take ? in_kind : req_kind_r;
    req_key_nxt  = in_take ? in_key : req_key_r;
    req_val_nxt  = in_take ? $unsigned(in_write_value) : req_val_r;

    occ_nxt = occ_r;
    if (commit && (req_kind_r == lkv_pkg::KindPut) && ~hit && ~evict) begin
      occ_nxt = occ_r + OccW'(1);
    end

    out_valid_nxt = out_valid_r & out_stall;
    out_hit_nxt   = out_hit_r;
    out_rv_nxt    = out_rv_r;
    out_ev_nxt    = out_ev_r;
    out_ek_nxt    = out_ek_r;
    if ((state_r == lkv_pkg::ST_UPDATE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = hit;
      out_rv_nxt    = (hit && (req_kind_r == lkv_pkg::KindGet)) ?
                      scan_link[ENTRIES].hv : '0;
      out_ev_nxt    = evict;
      out_ek_nxt    = evict ? scan_link[ENTRIES].ek : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkv_pkg::ST_IDLE;
      cap_r       <= lkv_pkg::CapReset;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_kind_r <= req_kind_nxt;
    req_key_r  <= req_key_nxt;
    req_val_r  <= req_val_nxt;
    out_hit_r  <= out_hit_nxt;
    out_rv_r   <= out_rv_nxt;
    out_ev_r   <= out_ev_nxt;
    out_ek_r   <= out_ek_nxt;
  end

  assign ctl.match_en = (state_r == lkv_pkg::ST_MATCH);
  assign ctl.commit   = commit;
  assign ctl.hit      = hit;
  assign ctl.evict    = evict;
  assign ctl.key      = req_key_r;

  // Head of the row: the accessed entry enters as most recent.
  assign ent_link[0].valid = 1'b1;
  assign ent_link[0].key   = req_key_r;
  assign ent_link[0].value = (hit && (req_kind_r == lkv_pkg::KindGet)) ?
                             scan_link[ENTRIES].hv : req_val_r;

  assign scan_link[0].seen = 1'b0;
  assign scan_link[0].hv   = '0;
  assign scan_link[0].ek   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .ent_in   (ent_link[i]),
      .ent_out  (ent_link[i+1]),
      .scan_in  (scan_link[i]),
      .scan_out (scan_link[i+1])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = $signed(out_rv_r);
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_ek_r;

endmodule
